// ----- rtl/pmq_pkg.sv -----
// shared types, codes and defaults for the priority message queue
`timescale 1ns / 1ps

package pmq_pkg;

    localparam int DEPTH_DEF         = 16;
    localparam int PRIO_LEVELS_DEF   = 32;
    localparam int MAX_MSG_BYTES_DEF = 8192;

    localparam int PRIO_W    = 8;
    localparam int LEN_W     = 14;
    localparam int DATA_W    = 32;
    localparam int OUT_PRIO_W = 5;
    localparam int OCC_W     = 5;
    localparam int MAXMSG_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [MAXMSG_W-1:0] MAX_MESSAGES_RST = 5'd16;
    localparam logic [LEN_W-1:0]    MAX_MSG_SIZE_RST = 14'd8192;

    typedef enum logic {
        REQ_SEND = 1'b0,
        REQ_RECV = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_PRIO  = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_BUF_SMALL = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_MESSAGES  = 2'd0,
        CFG_MAX_MSG_SIZE  = 2'd1,
        CFG_NOTIFY_ENABLE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage

// ----- rtl/pmq_req_if.sv -----
// request channel: send or receive beats
`timescale 1ns / 1ps

interface pmq_req_if;
    import pmq_pkg::*;

    logic                valid;
    logic                ready;
    req_type_t           req_type;
    logic [PRIO_W-1:0]   prio;
    logic [LEN_W-1:0]    length;
    logic [DATA_W-1:0]   payload;

    modport source (output valid, output req_type, output prio, output length,
                    output payload, input ready);
    modport sink   (input valid, input req_type, input prio, input length,
                    input payload, output ready);
endinterface

// ----- rtl/pmq_rsp_if.sv -----
// response channel: one beat per request
`timescale 1ns / 1ps

interface pmq_rsp_if;
    import pmq_pkg::*;

    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [DATA_W-1:0]     out_payload;
    logic [LEN_W-1:0]      out_length;
    logic [OUT_PRIO_W-1:0] out_prio;
    logic [OCC_W-1:0]      occupancy;
    logic                  notify;

    modport source (output valid, output status, output out_payload, output out_length,
                    output out_prio, output occupancy, output notify, input ready);
    modport sink   (input valid, input status, input out_payload, input out_length,
                    input out_prio, input occupancy, input notify, output ready);
endinterface

// ----- rtl/pmq_cfg_if.sv -----
// configuration write channel
`timescale 1ns / 1ps

interface pmq_cfg_if;
    import pmq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/pmq_cell.sv -----
// one slot of the sorted shift chain
`timescale 1ns / 1ps

module pmq_cell (
    input  logic                clk,
    input  pmq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  pmq_pkg::entry_t     new_entry,
    input  pmq_pkg::entry_t     prev_entry,
    input  logic                prev_ge,
    input  pmq_pkg::entry_t     next_entry,
    output pmq_pkg::entry_t     entry,
    output logic                ge
);
    import pmq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // held entry stays ahead of an arriving one of equal priority
    assign ge    = occupied && (entry_reg.prio >= new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.ins)
        begin
            if (!ge)
            begin
                entry_next = prev_ge ? new_entry : prev_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/priority_message_queue_unit.sv -----
// priority message queue: request decode, cell chain and response register
// a response is registered in the cycle after its request beat
// throughput: one request per cycle unless a held response stalls; every cell
// compares its priority in parallel and the whole chain shifts in the same cycle
// reset clears the entry count, the pending notification and the response valid and loads
// the configuration register defaults; entry contents are not reset and are read only below the count
`timescale 1ns / 1ps

module priority_message_queue_unit #(
    parameter int DEPTH         = pmq_pkg::DEPTH_DEF,
    parameter int PRIO_LEVELS   = pmq_pkg::PRIO_LEVELS_DEF,
    parameter int MAX_MSG_BYTES = pmq_pkg::MAX_MSG_BYTES_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    pmq_req_if.sink   req,
    pmq_rsp_if.source rsp,
    pmq_cfg_if.sink   cfg
);
    import pmq_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > MAXMSG_W) ? CW : MAXMSG_W;
    localparam int OCCX = (CW > OCC_W) ? CW : OCC_W;
    localparam int LIMW = 17;

    logic [CW-1:0]         count_reg, count_next;
    logic                  pending_reg, pending_next;
    logic [MAXMSG_W-1:0]   max_messages_reg;
    logic [LEN_W-1:0]      max_msg_size_reg;
    logic                  notify_en_reg;

    logic                  rsp_valid_reg;
    status_t               status_reg, status_next;
    logic [DATA_W-1:0]     payload_reg, payload_next;
    logic [LEN_W-1:0]      length_reg, length_next;
    logic [OUT_PRIO_W-1:0] prio_reg, prio_next;
    logic [OCC_W-1:0]      occ_reg;
    logic                  notify_reg, notify_next;

    logic                  accept;
    logic                  bad_prio, too_long, full, buf_small;
    logic [OCCX-1:0]       occ_ext;
    cell_ctrl_t            ctrl;
    entry_t                new_entry;
    entry_t                cell_entry [DEPTH];
    logic                  cell_ge    [DEPTH];
    logic                  occupied   [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign new_entry.prio    = req.prio;
    assign new_entry.length  = req.length;
    assign new_entry.payload = req.payload;

    assign bad_prio  = {1'b0, req.prio} >= (PRIO_W + 1)'(PRIO_LEVELS);
    assign too_long  = (req.length > max_msg_size_reg)
                    || (LIMW'(req.length) > LIMW'(MAX_MSG_BYTES));
    assign buf_small = (req.length < max_msg_size_reg)
                    && (LIMW'(req.length) < LIMW'(MAX_MSG_BYTES));
    assign full      = (CMPW'(count_reg) >= CMPW'(max_messages_reg))
                    || (count_reg == CW'(DEPTH));

    always_comb
    begin
        ctrl         = '0;
        count_next   = count_reg;
        pending_next = pending_reg;
        status_next  = ST_OK;
        payload_next = '0;
        length_next  = '0;
        prio_next    = '0;
        notify_next  = 1'b0;
        if (accept)
        begin
            unique case (req.req_type)
                REQ_SEND:
                begin
                    priority if (bad_prio)
                        status_next = ST_BAD_PRIO;
                    else if (too_long)
                        status_next = ST_TOO_LONG;
                    else if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (notify_en_reg && !pending_reg)
                        begin
                            pending_next = 1'b1;
                            notify_next  = 1'b1;
                        end
                    end
                end
                REQ_RECV:
                begin
                    priority if (buf_small)
                        status_next = ST_BUF_SMALL;
                    else if (count_reg == '0)
                        status_next = ST_EMPTY;
                    else
                    begin
                        ctrl.pop     = 1'b1;
                        count_next   = count_reg - 1'b1;
                        pending_next = 1'b0;
                        payload_next = cell_entry[0].payload;
                        length_next  = cell_entry[0].length;
                        prio_next    = cell_entry[0].prio[OUT_PRIO_W-1:0];
                    end
                end
                default: status_next = ST_OK;
            endcase
        end
        else if (cfg.valid && (cfg.index == CFG_NOTIFY_ENABLE))
        begin
            pending_next = 1'b0;
        end
    end

    assign occ_ext = OCCX'(count_next);

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign occupied[i] = CW'(i) < count_reg;
            pmq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occupied[i]),
                .new_entry  (new_entry),
                .prev_entry ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
                .prev_ge    ((i == 0) ? 1'b1 : cell_ge[(i == 0) ? 0 : i - 1]),
                .next_entry ((i == DEPTH - 1) ? new_entry
                                              : cell_entry[(i == DEPTH - 1) ? i : i + 1]),
                .entry      (cell_entry[i]),
                .ge         (cell_ge[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            pending_reg      <= 1'b0;
            max_messages_reg <= MAX_MESSAGES_RST;
            max_msg_size_reg <= MAX_MSG_SIZE_RST;
            notify_en_reg    <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_MAX_MESSAGES:  max_messages_reg <= cfg.data[MAXMSG_W-1:0];
                    CFG_MAX_MSG_SIZE:  max_msg_size_reg <= cfg.data;
                    CFG_NOTIFY_ENABLE: notify_en_reg    <= cfg.data[0];
                    default:           max_messages_reg <= max_messages_reg;
                endcase
            end
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            payload_reg <= payload_next;
            length_reg  <= length_next;
            prio_reg    <= prio_next;
            occ_reg     <= occ_ext[OCC_W-1:0];
            notify_reg  <= notify_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.out_payload = payload_reg;
    assign rsp.out_length  = length_reg;
    assign rsp.out_prio    = prio_reg;
    assign rsp.occupancy   = occ_reg;
    assign rsp.notify      = notify_reg;

endmodule
